// ===== rtl/core/utfss_pkg.sv =====
// utfss_pkg: shared types and constants of the utf-8 stream sanitiser
// beat structs for both channels, the group entry passed front to back,
// classification masks and the replacement character; no dependencies
package utfss_pkg;

    // default number of entries in the group queue between front and back
    localparam int unsigned QUEUE_DEPTH = 2;

    // lead-byte classification masks and patterns
    localparam logic [7:0] ASCII_MASK  = 8'h80;
    localparam logic [7:0] LEAD2_MASK  = 8'hE0;
    localparam logic [7:0] LEAD2_PAT   = 8'hC0;
    localparam logic [7:0] LEAD3_MASK  = 8'hF0;
    localparam logic [7:0] LEAD3_PAT   = 8'hE0;
    localparam logic [7:0] LEAD4_MASK  = 8'hF8;
    localparam logic [7:0] LEAD4_PAT   = 8'hF0;
    localparam logic [7:0] CONT_MASK   = 8'hC0;
    localparam logic [7:0] CONT_PAT    = 8'h80;

    // replacement character U+FFFD as utf-8
    localparam logic [7:0] REPL_BYTE0  = 8'hEF;
    localparam logic [7:0] REPL_BYTE1  = 8'hBF;
    localparam logic [7:0] REPL_BYTE2  = 8'hBD;

    // index of the last byte in a group
    localparam logic [1:0] LAST_IDX_ONE   = 2'd0;
    localparam logic [1:0] LAST_IDX_THREE = 2'd2;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       text_end;
    } in_beat_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
        logic       text_done;
    } out_beat_t;

    // one group of 1 to 4 output bytes caused by a single input beat
    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic [1:0]      last_idx;
        logic            text_end;
    } group_t;

endpackage

// ===== rtl/core/utfss_front.sv =====
// utfss_front: accepts input beats, tracks the open utf-8 sequence and
// turns each beat into at most one output group
// depends on utfss_pkg
module utfss_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  utfss_pkg::in_beat_t s_data,
    output logic                grp_valid,
    input  logic                grp_ready,
    output utfss_pkg::group_t   grp_data
);

    logic [1:0] bytes_left_reg, bytes_left_next;
    logic [2:0] seq_length_reg, seq_length_next;
    logic       seq_broken_reg, seq_broken_next;
    logic [7:0] held_reg [3];
    logic [7:0] held_next [3];

    logic       accept;
    logic [7:0] b;
    logic       is_end;
    logic [2:0] lead_len;
    logic [2:0] pos;
    logic       bad_cont;
    logic       broken_now;
    logic [1:0] left_dec;
    logic [2:0] len_m1;

    // queue space is the only thing that holds the input back
    assign s_ready = grp_ready;
    assign accept  = s_valid && s_ready;
    assign b       = s_data.in_byte;
    assign is_end  = s_data.text_end;

    always_comb begin
        if ((b & utfss_pkg::ASCII_MASK) == 8'h00) begin
            lead_len = 3'd1;
        end else if ((b & utfss_pkg::LEAD2_MASK) == utfss_pkg::LEAD2_PAT) begin
            lead_len = 3'd2;
        end else if ((b & utfss_pkg::LEAD3_MASK) == utfss_pkg::LEAD3_PAT) begin
            lead_len = 3'd3;
        end else if ((b & utfss_pkg::LEAD4_MASK) == utfss_pkg::LEAD4_PAT) begin
            lead_len = 3'd4;
        end else begin
            lead_len = 3'd0;
        end
    end

    assign pos        = seq_length_reg - {1'b0, bytes_left_reg};
    assign bad_cont   = (b & utfss_pkg::CONT_MASK) != utfss_pkg::CONT_PAT;
    assign broken_now = seq_broken_reg || bad_cont;
    assign left_dec   = bytes_left_reg - 2'd1;
    assign len_m1     = seq_length_reg - 3'd1;

    always_comb begin
        bytes_left_next = bytes_left_reg;
        seq_length_next = seq_length_reg;
        seq_broken_next = seq_broken_reg;
        held_next       = held_reg;
        grp_valid       = 1'b0;
        grp_data.bytes    = {utfss_pkg::REPL_BYTE0, utfss_pkg::REPL_BYTE2,
                             utfss_pkg::REPL_BYTE1, utfss_pkg::REPL_BYTE0};
        grp_data.last_idx = utfss_pkg::LAST_IDX_THREE;
        grp_data.text_end = is_end;

        if (accept) begin
            if (bytes_left_reg == 2'd0) begin
                if (lead_len == 3'd1) begin
                    grp_valid         = 1'b1;
                    grp_data.bytes[0] = b;
                    grp_data.last_idx = utfss_pkg::LAST_IDX_ONE;
                end else if (lead_len == 3'd0 || is_end) begin
                    // bad lead, or a lead that the text ends on
                    grp_valid = 1'b1;
                end else begin
                    held_next[0]    = b;
                    seq_length_next = lead_len;
                    bytes_left_next = 2'(lead_len - 3'd1);
                    seq_broken_next = 1'b0;
                end
            end else begin
                seq_broken_next = broken_now;
                bytes_left_next = left_dec;
                if (left_dec == 2'd0) begin
                    grp_valid = 1'b1;
                    if (!broken_now) begin
                        grp_data.bytes[0] = held_reg[0];
                        grp_data.bytes[1] = (seq_length_reg == 3'd2) ? b : held_reg[1];
                        grp_data.bytes[2] = (seq_length_reg == 3'd3) ? b : held_reg[2];
                        grp_data.bytes[3] = b;
                        grp_data.last_idx = len_m1[1:0];
                    end
                    bytes_left_next = 2'd0;
                    seq_length_next = 3'd0;
                    seq_broken_next = 1'b0;
                end else if (is_end) begin
                    grp_valid = 1'b1;
                end else begin
                    held_next[pos[1:0]] = b;
                end
            end

            if (is_end) begin
                bytes_left_next = 2'd0;
                seq_length_next = 3'd0;
                seq_broken_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bytes_left_reg <= 2'd0;
            seq_length_reg <= 3'd0;
            seq_broken_reg <= 1'b0;
        end else begin
            bytes_left_reg <= bytes_left_next;
            seq_length_reg <= seq_length_next;
            seq_broken_reg <= seq_broken_next;
        end
    end

    always_ff @(posedge aclk) begin
        held_reg <= held_next;
    end

endmodule

// ===== rtl/core/utfss_queue.sv =====
// utfss_queue: small register queue of output groups between front and back
// depends on utfss_pkg
module utfss_queue #(
    parameter int unsigned Depth = utfss_pkg::QUEUE_DEPTH
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push_valid,
    output logic              push_ready,
    input  utfss_pkg::group_t push_data,
    output logic              pop_valid,
    input  logic              pop_ready,
    output utfss_pkg::group_t pop_data
);

    localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int unsigned CntW = $clog2(Depth + 1);
    localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
    localparam logic [CntW-1:0] CntFull = CntW'(Depth);

    utfss_pkg::group_t entry_reg [Depth];

    logic [PtrW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0] count_reg, count_next;
    logic            do_push, do_pop;

    assign push_ready = count_reg != CntFull;
    assign pop_valid  = count_reg != '0;
    assign pop_data   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PtrLast) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PtrLast) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== rtl/core/utfss_back.sv =====
// utfss_back: plays each queued group out as single output beats and
// marks the last beat of the group and of the text
// depends on utfss_pkg
module utfss_back (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 grp_valid,
    output logic                 grp_ready,
    input  utfss_pkg::group_t    grp_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output utfss_pkg::out_beat_t m_data
);

    utfss_pkg::group_t cur_reg;
    logic              busy_reg, busy_next;
    logic [1:0]        idx_reg, idx_next;
    logic              at_last;
    logic              load;

    assign at_last   = idx_reg == cur_reg.last_idx;
    assign grp_ready = !busy_reg || (m_ready && at_last);
    assign load      = grp_valid && grp_ready;

    assign m_valid            = busy_reg;
    assign m_data.out_byte    = cur_reg.bytes[idx_reg];
    assign m_data.run_last    = at_last;
    assign m_data.text_done   = at_last && cur_reg.text_end;

    always_comb begin
        busy_next = busy_reg;
        idx_next  = idx_reg;
        if (load) begin
            busy_next = 1'b1;
            idx_next  = 2'd0;
        end else if (busy_reg && m_ready) begin
            if (at_last) begin
                busy_next = 1'b0;
            end else begin
                idx_next = idx_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            idx_reg  <= 2'd0;
        end else begin
            busy_reg <= busy_next;
            idx_reg  <= idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            cur_reg <= grp_data;
        end
    end

endmodule

// ===== rtl/core/utf8_stream_sanitizer.sv =====
// utf8_stream_sanitizer: top level of the utf-8 stream sanitiser
// joins front, group queue and back; depends on utfss_pkg, utfss_front,
// utfss_queue and utfss_back
//
//  channel  dir  ports                      beat
//  input    in   s_valid s_ready s_data     one raw text byte plus end-of-text flag
//  result   out  m_valid m_ready m_data     one sanitised byte plus run and text marks
//
// one input beat is taken per cycle while the group queue has space
// each input beat makes a group of 0 to 4 output bytes; the back end sends
// one byte per cycle while m_ready is high, so a group of n bytes holds the back end
// until its n bytes are taken; ascii text runs at one byte per cycle end to end while
// m_ready is high, and replacement groups can fill the queue and then stall s_ready
// aresetn is synchronous and active low; it empties the queue and closes any
// open sequence, and the block is ready as soon as reset is released
module utf8_stream_sanitizer #(
    parameter int unsigned QueueDepth = utfss_pkg::QUEUE_DEPTH
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  utfss_pkg::in_beat_t  s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output utfss_pkg::out_beat_t m_data
);

    // front to queue
    logic              fq_valid;
    logic              fq_ready;
    utfss_pkg::group_t fq_data;

    // queue to back
    logic              qb_valid;
    logic              qb_ready;
    utfss_pkg::group_t qb_data;

    // front end: lead classification, continuation check, byte holding
    utfss_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .grp_valid (fq_valid),
        .grp_ready (fq_ready),
        .grp_data  (fq_data)
    );

    // decouples the bursty back end from the byte-rate front end
    utfss_queue #(
        .Depth (QueueDepth)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (fq_valid),
        .push_ready (fq_ready),
        .push_data  (fq_data),
        .pop_valid  (qb_valid),
        .pop_ready  (qb_ready),
        .pop_data   (qb_data)
    );

    // back end: serialises groups onto the result channel
    utfss_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .grp_valid (qb_valid),
        .grp_ready (qb_ready),
        .grp_data  (qb_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

// ===== rtl/core/utfss_checker.sv =====
// utfss_checker: port-level assertions for utf8_stream_sanitizer, bound to
// the top level; depends on utfss_pkg
module utfss_checker (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_ready,
    input logic                 m_valid,
    input logic                 m_ready,
    input utfss_pkg::out_beat_t m_data
);

    // a stalled result beat holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result beat changed while stalled");

    // end of text only on the last beat of a run
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (!m_data.text_done || m_data.run_last))
        else $error("text_done without run_last");

    // a run that is not finished goes on in the next cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_data.run_last |=> m_valid)
        else $error("run broken off before its last beat");

    // reset leaves no result pending and the input side open
    assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready)
        else $error("result valid or input blocked straight after reset");

endmodule

bind utf8_stream_sanitizer utfss_checker u_utfss_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

// ===== dv/utf8_stream_sanitizer_tb.sv =====
// utf8_stream_sanitizer_tb: self-checking testbench of the utf-8 stream sanitiser
// holds a scoreboard class that predicts the sanitised byte stream, plus the top module
// depends on utfss_pkg and the utf8_stream_sanitizer rtl
`timescale 1ns / 1ps

class utf8_scoreboard;
    utfss_pkg::out_beat_t pending_q [$];
    utfss_pkg::out_beat_t burst [$];
    logic [1:0] owed = '0;
    logic [2:0] seq_len = '0;
    logic [7:0] held [3];
    bit         broken = 1'b0;
    int unsigned beats_in = 0;
    int unsigned beats_out = 0;
    int unsigned replacements = 0;
    int unsigned texts = 0;
    int unsigned mismatches = 0;

    function utfss_pkg::out_beat_t plain_beat(logic [7:0] b);
        utfss_pkg::out_beat_t ob;
        ob.out_byte  = b;
        ob.run_last  = 1'b0;
        ob.text_done = 1'b0;
        return ob;
    endfunction

    function void add_replacement();
        burst.push_back(plain_beat(utfss_pkg::REPL_BYTE0));
        burst.push_back(plain_beat(utfss_pkg::REPL_BYTE1));
        burst.push_back(plain_beat(utfss_pkg::REPL_BYTE2));
        replacements++;
    endfunction

    function void close_sequence();
        owed    = '0;
        seq_len = '0;
        broken  = 1'b0;
    endfunction

    function void note_beat(utfss_pkg::in_beat_t beat);
        logic [7:0] b;
        int lead_len;
        int pos;
        b = beat.in_byte;
        burst.delete();
        beats_in++;
        if (beat.text_end)
            texts++;
        if (owed == 2'd0) begin
            if ((b & utfss_pkg::ASCII_MASK) == 8'h00)
                lead_len = 1;
            else if ((b & utfss_pkg::LEAD2_MASK) == utfss_pkg::LEAD2_PAT)
                lead_len = 2;
            else if ((b & utfss_pkg::LEAD3_MASK) == utfss_pkg::LEAD3_PAT)
                lead_len = 3;
            else if ((b & utfss_pkg::LEAD4_MASK) == utfss_pkg::LEAD4_PAT)
                lead_len = 4;
            else
                lead_len = 0;

            if (lead_len == 1) begin
                burst.push_back(plain_beat(b));
            end else if (lead_len == 0 || beat.text_end) begin
                add_replacement();
            end else begin
                held[0] = b;
                seq_len = 3'(lead_len);
                owed    = 2'(lead_len - 1);
                broken  = 1'b0;
            end
        end else begin
            pos = int'(seq_len) - int'(owed);
            // a bad continuation still counts towards the sequence
            if ((b & utfss_pkg::CONT_MASK) != utfss_pkg::CONT_PAT)
                broken = 1'b1;
            owed = owed - 2'd1;
            if (owed == 2'd0) begin
                if (broken) begin
                    add_replacement();
                end else begin
                    for (int i = 0; i < int'(seq_len) - 1; i++)
                        burst.push_back(plain_beat(held[i]));
                    burst.push_back(plain_beat(b));
                end
                close_sequence();
            end else if (beat.text_end) begin
                add_replacement();
                close_sequence();
            end else begin
                held[pos] = b;
            end
        end
        if (beat.text_end)
            close_sequence();
        if (burst.size() > 0) begin
            burst[burst.size() - 1].run_last  = 1'b1;
            burst[burst.size() - 1].text_done = beat.text_end;
        end
        foreach (burst[i])
            pending_q.push_back(burst[i]);
    endfunction

    task report_mismatch(string what);
        $display("[%0t] mismatch: %s", $realtime, what);
        mismatches++;
    endtask

    task check_beat(utfss_pkg::out_beat_t got);
        utfss_pkg::out_beat_t want;
        if (pending_q.size() == 0) begin
            report_mismatch($sformatf("unexpected beat byte %02h", got.out_byte));
            return;
        end
        want = pending_q.pop_front();
        beats_out++;
        if (got.out_byte !== want.out_byte)
            report_mismatch($sformatf("out_byte %02h, want %02h",
                                      got.out_byte, want.out_byte));
        if (got.run_last !== want.run_last)
            report_mismatch($sformatf("run_last %b, want %b on byte %02h",
                                      got.run_last, want.run_last, want.out_byte));
        if (got.text_done !== want.text_done)
            report_mismatch($sformatf("text_done %b, want %b on byte %02h",
                                      got.text_done, want.text_done, want.out_byte));
    endtask
endclass

module utf8_stream_sanitizer_tb;

    // clock and a synchronous active-low reset
    logic      aclk = 1'b0;
    logic      aresetn = 1'b0;

    // input channel, idle from time zero
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    utfss_pkg::in_beat_t  s_data = '0;

    // result channel
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    utfss_pkg::out_beat_t m_data;

    // set for a stretch of the random phase: neither side inserts gaps
    bit        steady = 1'b0;
    int        random_beats = 0;

    utf8_scoreboard sb = new;

    utf8_stream_sanitizer uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always #5 aclk = ~aclk;

    // sink side: ready drops with a chance of roughly 38 in a hundred, except in the steady stretch
    always @(posedge aclk) begin
        if (!aresetn)
            m_ready <= 1'b0;
        else
            m_ready <= steady || ($urandom_range(99) >= 38);
    end

    // one monitor watches both channels at the same edge, input side first,
    // so every result finds its prediction already queued
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready)
                sb.note_beat(s_data);
            if (m_valid && m_ready)
                sb.check_beat(m_data);
        end
    end

    // present one input beat, with random gaps ahead of it, and hold it until taken
    task automatic send_beat(input logic [7:0] b, input logic last);
        while (!steady && $urandom_range(99) < 38) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= '{in_byte: b, text_end: last};
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
    endtask

    // send the n bytes packed msb first in w; text end optionally on the final one
    task automatic send_run(input int n, input logic [31:0] w, input logic last);
        for (int i = n - 1; i >= 0; i--)
            send_beat(w[i*8 +: 8], last && (i == 0));
    endtask

    // one random character: mostly ascii and well-formed multibyte forms,
    // some with a corrupted continuation, plus raw noise bytes;
    // text end lands at random, now and then in the middle of a sequence
    task automatic send_random_char();
        int kind;
        int len;
        int bad;
        int top;
        logic [31:0] w;
        kind = int'($urandom_range(99));
        w = '0;
        if (kind < 45) begin
            len = 1;
            w[6:0] = 7'($urandom_range(127));
        end else if (kind < 90) begin
            len = int'($urandom_range(4, 2));
            w = $urandom;
            for (int i = 0; i < len - 1; i++)
                w[i*8 +: 8] = {utfss_pkg::CONT_PAT[7:6], w[i*8 +: 6]};
            case (len)
                2: begin
                    w[15:8] = {utfss_pkg::LEAD2_PAT[7:5], w[12:8]};
                end
                3: begin
                    w[23:16] = {utfss_pkg::LEAD3_PAT[7:4], w[19:16]};
                end
                default: begin
                    w[31:24] = {utfss_pkg::LEAD4_PAT[7:3], w[26:24]};
                end
            endcase
            if (kind >= 80) begin
                // break one continuation: top bits 00, 01 or 11
                bad = int'($urandom_range(len - 2));
                top = int'($urandom_range(2));
                w[bad*8 + 6 +: 2] = (top == 2) ? 2'b11 : 2'(top);
            end
        end else begin
            len = 1;
            w[7:0] = 8'($urandom_range(255));
        end
        for (int i = len - 1; i >= 0; i--) begin
            send_beat(w[i*8 +: 8], $urandom_range(19) == 0);
            random_beats++;
        end
    endtask

    initial begin
        int spin;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: ascii extremes and one well-formed character of each length
        send_run(2, 32'h0000_007F, 1'b0);
        send_run(2, 32'h0000_C2A9, 1'b0);
        send_run(3, 32'h00E2_82AC, 1'b0);
        send_run(4, 32'hF09F_9880, 1'b0);
        // bad lead bytes: a stray continuation, the first code past the 4-byte leads, all ones
        send_run(1, 32'h0000_0080, 1'b0);
        send_run(1, 32'h0000_00F8, 1'b0);
        send_run(1, 32'h0000_00FF, 1'b0);
        // bad continuations: ascii inside a sequence, and a byte that looks like a lead
        send_run(2, 32'h0000_C341, 1'b0);
        send_run(3, 32'h00E2_C3A9, 1'b0);
        // text ending inside a sequence, on a lone lead, on a completing byte and on a bad lead
        send_run(2, 32'h0000_E282, 1'b1);
        send_run(1, 32'h0000_00C3, 1'b1);
        send_run(2, 32'h0000_C3A9, 1'b1);
        send_run(3, 32'h00F0_9F98, 1'b1);
        send_run(1, 32'h0000_0080, 1'b1);

        // random: a quiet stretch in the middle with no gaps on either side
        while (random_beats < 132) begin
            steady = (random_beats >= 60) && (random_beats < 110);
            send_random_char();
        end
        steady = 1'b0;
        s_valid <= 1'b0;

        // let the monitor take the last input, drain, bounded, then settle
        repeat (2) @(posedge aclk);
        for (spin = 0; spin < 20000 && sb.pending_q.size() != 0; spin++)
            @(posedge aclk);
        repeat (50) @(posedge aclk);
        if (sb.pending_q.size() != 0)
            sb.report_mismatch($sformatf("%0d predicted beats never arrived",
                                         sb.pending_q.size()));

        $display("run covered %0d input beats over %0d texts, %0d output beats checked",
                 sb.beats_in, sb.texts, sb.beats_out);
        $display("replacement characters predicted: %0d, mismatches: %0d",
                 sb.replacements, sb.mismatches);
        if (sb.mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // watchdog: far beyond the slowest legal run
    initial begin
        #2000000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
